FILE: rtl/core/tscrt_pkg.sv
// ----------------------------------------------------------------------------
// Time-sorted call record table package
// Shared types and constants for the record table cells and top level.
// ----------------------------------------------------------------------------
package tscrt_pkg;

   localparam int TSCRT_DEPTH = 40;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int STAMP_W     = 40;

   // Request codes; the fourth code is unused and leaves the table alone.
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_READ   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   // What every cell of the chain does in the current cycle.
   typedef enum logic [1:0] {
      CELL_IDLE,
      CELL_ADD_OPEN,
      CELL_ADD_FULL,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic               is_new;
      logic [31:0]        payload;
   } cell_rec_type;

   typedef struct packed {
      cell_op_type  op;
      cell_rec_type rec;
      logic [IDX_W-1:0] index;
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  index;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        is_new;
      logic [31:0] payload;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic        out_is_new;
      logic [31:0] out_payload;
      logic [6:0]  record_count;
      logic [6:0]  new_count;
   } rsp_item_type;

endpackage

FILE: rtl/core/time_sorted_call_record_table_top.sv
// ----------------------------------------------------------------------------
// Time-sorted call record table
// Keeps up to DEPTH call records in ascending stamp order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: a request transfer on req_* carries an add, a delete at an index or
// a read at an index. Every request yields exactly one response transfer on
// rsp_* with a status, the record read (zero unless a read succeeds), the
// number of records held and the number flagged new after the request.
// A request is registered at its transfer and executed in every cell at once
// as soon as the output register is free or emptying. Its response is loaded
// into the output register at the end of the execute cycle. Only one request
// is held at a time, so req_ready stays low until its response is loaded.
// When the receiver stalls, the response holds in the output register and
// the request behind it waits in the request register. Synchronous reset
// empties the table (record and new counts go to zero), drops any pending
// request and response, and raises req_ready in the next cycle. No clearing
// pass is needed because the record storage is only read below the count.
// ----------------------------------------------------------------------------
module time_sorted_call_record_table_top
   import tscrt_pkg::*;
#(
   parameter int DEPTH = TSCRT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [FW-1:0] FULL = FW'(DEPTH);

   // Request holding register; pend_ff marks a request waiting to execute.
   logic         pend_ff;
   logic         pend_in;
   req_item_type req_ff;

   // Response output register.
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;

   // Record and new-flag counts are kept running so no tally over cells.
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] newc_ff;
   logic [FW-1:0] newc_in;

   logic         exec;
   logic         full;
   logic         idx_ok;
   cell_cmd_type cmd;
   cell_rec_type rec_new;
   cell_rec_type rd_rec;

   logic         valid_v [DEPTH];
   logic         later_v [DEPTH];
   cell_rec_type rec_v   [DEPTH];

   assign req_ready = !pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A pending request executes once the output register is free or emptying.
   assign exec   = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign full   = (fill_ff == FULL);
   assign idx_ok = CNT_W'(req_ff.index) < CNT_W'(fill_ff);

   assign rec_new.stamp   = {req_ff.year, req_ff.month, req_ff.day,
                             req_ff.hour, req_ff.minute, req_ff.second};
   assign rec_new.is_new  = req_ff.is_new;
   assign rec_new.payload = req_ff.payload;

   always_comb begin
      cmd.op    = CELL_IDLE;
      cmd.rec   = rec_new;
      cmd.index = req_ff.index;
      if (exec) begin
         case (req_ff.req_type)
            REQ_ADD:    cmd.op = full ? CELL_ADD_FULL : CELL_ADD_OPEN;
            REQ_DELETE: cmd.op = idx_ok ? CELL_DELETE : CELL_IDLE;
            default:    cmd.op = CELL_IDLE;
         endcase
      end
   end

   // The chain of cells. Slot zero holds the oldest record.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic         vl;
      logic         vr;
      logic         ll;
      logic         lr;
      cell_rec_type rl;
      cell_rec_type rr;

      assign valid_v[i] = FW'(i) < fill_ff;

      if (i == 0) begin : g_first
         assign vl = 1'b0;
         assign ll = 1'b0;
         assign rl = '0;
      end else begin : g_mid_l
         assign vl = valid_v[i-1];
         assign ll = later_v[i-1];
         assign rl = rec_v[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign vr = 1'b0;
         assign lr = 1'b0;
         assign rr = '0;
      end else begin : g_mid_r
         assign vr = valid_v[i+1];
         assign lr = later_v[i+1];
         assign rr = rec_v[i+1];
      end

      tscrt_cell #(
         .DEPTH (DEPTH),
         .POS   (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid_self  (valid_v[i]),
         .valid_left  (vl),
         .valid_right (vr),
         .later_left  (ll),
         .later_right (lr),
         .rec_left    (rl),
         .rec_right   (rr),
         .later_self  (later_v[i]),
         .rec_out     (rec_v[i])
      );
   end

   // Selects the record at the requested index: each cell matches its own
   // position, and the matches are merged with an OR.
   always_comb begin
      rd_rec = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_v[i] && (req_ff.index == IDX_W'(i))) begin
            rd_rec = rd_rec | rec_v[i];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      newc_in = newc_ff;
      rsp_in  = '0;
      rsp_in.status = ST_OK;
      case (req_ff.req_type)
         REQ_ADD: begin
            if (full) begin
               if (later_v[0]) begin
                  // The new record is older than every record held.
                  rsp_in.status = ST_REFUSED;
               end else begin
                  newc_in = newc_ff - FW'(rec_v[0].is_new) + FW'(req_ff.is_new);
               end
            end else begin
               fill_in = fill_ff + FW'(1);
               newc_in = newc_ff + FW'(req_ff.is_new);
            end
         end
         REQ_DELETE: begin
            if (idx_ok) begin
               fill_in = fill_ff - FW'(1);
               newc_in = newc_ff - FW'(rd_rec.is_new);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         REQ_READ: begin
            if (idx_ok) begin
               rsp_in.out_year    = rd_rec.stamp[39:26];
               rsp_in.out_month   = rd_rec.stamp[25:22];
               rsp_in.out_day     = rd_rec.stamp[21:17];
               rsp_in.out_hour    = rd_rec.stamp[16:12];
               rsp_in.out_minute  = rd_rec.stamp[11:6];
               rsp_in.out_second  = rd_rec.stamp[5:0];
               rsp_in.out_is_new  = rd_rec.is_new;
               rsp_in.out_payload = rd_rec.payload;
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      rsp_in.record_count = CNT_W'(fill_in);
      rsp_in.new_count    = CNT_W'(newc_in);
   end

   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (req_valid && req_ready) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         newc_ff      <= '0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            fill_ff <= fill_in;
            newc_ff <= newc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/core/tscrt_cell.sv
// ----------------------------------------------------------------------------
// Record table cell
// One slot of the sorted chain: compares its stamp with the broadcast one and
// holds, loads the new record, or takes a neighbor's record.
// ----------------------------------------------------------------------------
module tscrt_cell
   import tscrt_pkg::*;
#(
   parameter int DEPTH = TSCRT_DEPTH,
   parameter int POS   = 0
) (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         valid_self,
   input  logic         valid_left,
   input  logic         valid_right,
   input  logic         later_left,
   input  logic         later_right,
   input  cell_rec_type rec_left,
   input  cell_rec_type rec_right,
   output logic         later_self,
   output cell_rec_type rec_out
);

   localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(POS);
   localparam logic IS_FIRST = (POS == 0);
   localparam logic IS_LAST  = (POS == DEPTH - 1);

   cell_rec_type rec_ff;
   cell_rec_type rec_in;
   logic         take_left;
   logic         take_right;
   logic         load;

   assign later_self = valid_self && (rec_ff.stamp > cmd.rec.stamp);
   assign rec_out    = rec_ff;

   always_comb begin
      take_left  = 1'b0;
      take_right = 1'b0;
      load       = 1'b0;
      case (cmd.op)
         CELL_ADD_OPEN: begin
            // Records later than the new one move up by one slot.
            take_left = later_left;
            load      = !later_left && (IS_FIRST || valid_left)
                        && (later_self || !valid_self);
         end
         CELL_ADD_FULL: begin
            // Records not later move down; the oldest falls out of slot zero.
            take_right = !IS_LAST && !later_right && !later_self;
            load       = !later_self && (IS_LAST || later_right);
         end
         CELL_DELETE: begin
            take_right = (cmd.index <= POS_IDX) && valid_right;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rec_in = rec_ff;
      if (load) begin
         rec_in = cmd.rec;
      end else if (take_left) begin
         rec_in = rec_left;
      end else if (take_right) begin
         rec_in = rec_right;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

FILE: rtl/core/tscrt_checker.sv
// ----------------------------------------------------------------------------
// Record table port checker
// Watches the top-level ports of the record table and flags misbehavior.
// ----------------------------------------------------------------------------
module tscrt_checker
   import tscrt_pkg::*;
#(
   parameter int DEPTH = TSCRT_DEPTH
) (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Only one request is held at a time.
   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is pending");

   // Counts stay within the table size, and new records are a subset.
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.record_count <= CNT_W'(DEPTH))
                    && (rsp_data.new_count <= rsp_data.record_count))
      else $error("record counts out of range");

   // A failed or refused request returns no record.
   a_no_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK)
         |-> (rsp_data.out_payload == '0) && (rsp_data.out_year == '0)
             && (rsp_data.out_is_new == 1'b0))
      else $error("record returned with error status");

   // Reset leaves no response and an open request side.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state after reset wrong");

endmodule

bind time_sorted_call_record_table_top tscrt_checker #(.DEPTH(DEPTH)) u_tscrt_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Time-sorted call record table testbench
// Drives add, delete, read and unused requests through the valid/ready
// request channel. Every response transfer is checked field by field against
// an in-order predictor of the sorted table or a scripted line's own response.
// A short scripted pass covers the corner cases, including a full table. A
// long random pass follows, run under four idle and back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_top;
   import tscrt_pkg::*;

   // The fourth request code has no name in the package; the table must ignore it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Generous cycle budget.
   localparam int CYCLE_LIMIT = 400_000;
   // Cycles to keep watching for stray responses once the queue has drained.
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PER_PHASE = 400;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic               is_new;
      logic [31:0]        payload;
   } held_record_type;

   // One line of the scripted pass. A line with reps above one is a burst of
   // adds with stamp and payload stepped by one and the new flag alternating.
   // Where typed is set, the response is the one written in the line.
   typedef struct {
      logic [1:0]         kind;
      logic [IDX_W-1:0]   index;
      logic [STAMP_W-1:0] stamp;
      logic               is_new;
      logic [31:0]        payload;
      int                 reps;
      bit                 typed;
      rsp_item_type       want;
   } script_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   // The predictor's own copy of the table.
   held_record_type table_slots [TSCRT_DEPTH];
   int              table_fill = 0;

   // Responses still owed by the block, oldest first.
   rsp_item_type awaited_responses [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;

   script_row_type scripted_rows [21];

   time_sorted_call_record_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Builds a response by hand for the scripted lines whose outcome is plain.
   function automatic rsp_item_type want_rsp(input status_type status,
                                             input logic [STAMP_W-1:0] stamp,
                                             input logic is_new,
                                             input logic [31:0] payload,
                                             input int count, input int fresh);
      rsp_item_type r;
      r = '0;
      r.status = status;
      {r.out_year, r.out_month, r.out_day, r.out_hour, r.out_minute,
       r.out_second} = stamp;
      r.out_is_new   = is_new;
      r.out_payload  = payload;
      r.record_count = CNT_W'(count);
      r.new_count    = CNT_W'(fresh);
      return r;
   endfunction

   // Applies one request to the predicted table and returns the response it
   // must produce. The stamp compares as one unsigned number, year on top.
   function automatic rsp_item_type apply_table_request(input req_item_type it);
      rsp_item_type    r;
      held_record_type incoming;
      int              slot;
      int              i;
      int              fresh;
      r = '0;
      incoming.stamp = {it.year, it.month, it.day, it.hour, it.minute, it.second};
      incoming.is_new = it.is_new;
      incoming.payload = it.payload;
      case (it.req_type)
         REQ_ADD: begin
            // The insertion point is the first record with a later stamp, so
            // records with equal stamps keep their arrival order.
            slot = table_fill;
            for (i = table_fill - 1; i >= 0; i--) begin
               if (table_slots[i].stamp > incoming.stamp) slot = i;
            end
            if (table_fill >= TSCRT_DEPTH) begin
               // Full: the head falls out and the records ahead of the slot
               // move down one position. Nothing older than all is taken.
               if (slot == 0) begin
                  r.status = ST_REFUSED;
               end else begin
                  for (i = 0; i + 1 < slot; i++) table_slots[i] = table_slots[i + 1];
                  table_slots[slot - 1] = incoming;
               end
            end else begin
               for (i = table_fill; i > slot; i--) table_slots[i] = table_slots[i - 1];
               table_slots[slot] = incoming;
               table_fill++;
            end
         end
         REQ_DELETE: begin
            if (int'(it.index) >= table_fill) begin
               r.status = ST_RANGE;
            end else begin
               for (i = int'(it.index); i + 1 < table_fill; i++) begin
                  table_slots[i] = table_slots[i + 1];
               end
               table_fill--;
               table_slots[table_fill].is_new = 1'b0;
            end
         end
         REQ_READ: begin
            if (int'(it.index) >= table_fill) begin
               r.status = ST_RANGE;
            end else begin
               {r.out_year, r.out_month, r.out_day, r.out_hour, r.out_minute,
                r.out_second} = table_slots[it.index].stamp;
               r.out_is_new  = table_slots[it.index].is_new;
               r.out_payload = table_slots[it.index].payload;
            end
         end
         default: begin
         end
      endcase
      fresh = 0;
      for (i = 0; i < table_fill; i++) begin
         if (table_slots[i].is_new) fresh++;
      end
      r.record_count = CNT_W'(table_fill);
      r.new_count    = CNT_W'(fresh);
      return r;
   endfunction

   // Random request. In a filling stretch adds dominate, so the table reaches
   // its full state and stays there. In a draining stretch deletes dominate.
   // Most stamps come from a narrow window, which makes equal stamps and
   // records older than the whole table common. The rest are random over
   // every bit of each field.
   function automatic req_item_type random_request(input bit filling);
      req_item_type it;
      logic [95:0]  bits;
      int           roll;
      bits = {$urandom, $urandom, $urandom};
      it = bits[$bits(req_item_type)-1:0];
      roll = $urandom_range(99);
      if (roll < 5) it.req_type = REQ_UNUSED;
      else if (roll < (filling ? 75 : 30)) it.req_type = REQ_ADD;
      else if (roll < (filling ? 85 : 75)) it.req_type = REQ_DELETE;
      else it.req_type = REQ_READ;
      // Mostly indexes from zero up to the fill level, with one past the end included.
      if ($urandom_range(9) < 7) it.index = IDX_W'($urandom_range(0, table_fill));
      if ($urandom_range(3) != 0) begin
         it.year   = 14'($urandom_range(2020, 2021));
         it.month  = 4'($urandom_range(1, 2));
         it.day    = 5'($urandom_range(1, 3));
         it.hour   = 5'($urandom_range(0, 1));
         it.minute = 6'($urandom_range(0, 1));
         it.second = 6'($urandom_range(0, 3));
      end
      return it;
   endfunction

   // Presents one request and holds it until the transfer. The expected
   // response is queued at the transfer edge, since the block serves requests
   // strictly in order. A random hold-off before the request sets the
   // sender's idle rate. Valid is lowered only when a hold-off follows, so it
   // never gets two assignments in one step.
   task automatic send_request(input req_item_type it, input bit typed,
                               input rsp_item_type want);
      rsp_item_type predicted;
      int           hold;
      hold = 0;
      while ($urandom_range(99) < sender_idle_pct) hold++;
      if (hold > 0) begin
         req_valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      // The predictor runs on every request, so the table stays in step even
      // where the scripted line gives the response itself.
      predicted = apply_table_request(it);
      awaited_responses.push_back(typed ? want : predicted);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_response(input rsp_item_type got);
      rsp_item_type want;
      if (awaited_responses.size() == 0) begin
         $error("response transfer with none outstanding: status %0d count %0d",
                got.status, got.record_count);
         mismatch_count++;
      end else begin
         want = awaited_responses.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("out_year", 64'(want.out_year), 64'(got.out_year));
         compare_field("out_month", 64'(want.out_month), 64'(got.out_month));
         compare_field("out_day", 64'(want.out_day), 64'(got.out_day));
         compare_field("out_hour", 64'(want.out_hour), 64'(got.out_hour));
         compare_field("out_minute", 64'(want.out_minute), 64'(got.out_minute));
         compare_field("out_second", 64'(want.out_second), 64'(got.out_second));
         compare_field("out_is_new", 64'(want.out_is_new), 64'(got.out_is_new));
         compare_field("out_payload", 64'(want.out_payload), 64'(got.out_payload));
         compare_field("record_count", 64'(want.record_count),
                       64'(got.record_count));
         compare_field("new_count", 64'(want.new_count), 64'(got.new_count));
      end
   endtask

   // Response side. Outputs are sampled at the edge, before they update, and
   // ready is redrawn every cycle for the current stall rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog. A hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      int           n;
      int           r;
      int           phase;

      // Scripted pass. The first lines run on an empty table, where every
      // response is plain. Then a burst fills the table past its depth, and
      // the full-table adds follow: a drop at the head, a refusal of a record
      // older than all, and an add at the tail.
      scripted_rows = '{
         '{REQ_READ, 6'd0, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_RANGE, '0, 1'b0, 32'd0, 0, 0)},
         '{REQ_DELETE, 6'd63, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_RANGE, '0, 1'b0, 32'd0, 0, 0)},
         '{REQ_UNUSED, 6'd0, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_OK, '0, 1'b0, 32'd0, 0, 0)},
         '{REQ_ADD, 6'd0, STAMP_MAX, 1'b1, 32'hFFFF_FFFF, 1, 1'b1,
           want_rsp(ST_OK, '0, 1'b0, 32'd0, 1, 1)},
         '{REQ_ADD, 6'd0, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_OK, '0, 1'b0, 32'd0, 2, 1)},
         '{REQ_READ, 6'd0, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_OK, '0, 1'b0, 32'd0, 2, 1)},
         '{REQ_READ, 6'd1, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_OK, STAMP_MAX, 1'b1, 32'hFFFF_FFFF, 2, 1)},
         '{REQ_READ, 6'd2, '0, 1'b0, 32'd0, 1, 1'b1,
           want_rsp(ST_RANGE, '0, 1'b0, 32'd0, 2, 1)},
         // Equal stamp: must land behind the record already there.
         '{REQ_ADD, 6'd0, '0, 1'b1, 32'h1234_5678, 1, 1'b0, '0},
         '{REQ_READ, 6'd1, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_DELETE, 6'd0, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_ADD, 6'd0, {14'd2000, 4'd6, 5'd15, 5'd12, 6'd30, 6'd0}, 1'b0,
           32'hA000_0000, TSCRT_DEPTH, 1'b0, '0},
         '{REQ_ADD, 6'd0, {14'd2000, 4'd6, 5'd15, 5'd12, 6'd30, 6'd20}, 1'b1,
           32'h0BAD_F00D, 1, 1'b0, '0},
         '{REQ_ADD, 6'd0, '0, 1'b1, 32'h5555_AAAA, 1, 1'b0, '0},
         '{REQ_ADD, 6'd0, STAMP_MAX, 1'b0, 32'h0F0F_0F0F, 1, 1'b0, '0},
         '{REQ_READ, 6'd39, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_READ, 6'd40, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_DELETE, 6'd39, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_DELETE, 6'd0, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_READ, 6'd63, '0, 1'b0, 32'd0, 1, 1'b0, '0},
         '{REQ_DELETE, 6'd38, '0, 1'b0, 32'd0, 1, 1'b0, '0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (scripted_rows[n]) begin
         for (r = 0; r < scripted_rows[n].reps; r++) begin
            it = '0;
            it.req_type = scripted_rows[n].kind;
            it.index    = scripted_rows[n].index;
            {it.year, it.month, it.day, it.hour, it.minute, it.second} =
               scripted_rows[n].stamp + r;
            it.is_new   = (scripted_rows[n].reps > 1) ? r[0] : scripted_rows[n].is_new;
            it.payload  = scripted_rows[n].payload + r;
            send_request(it, scripted_rows[n].typed, scripted_rows[n].want);
         end
      end

      // Random pass under four profiles: no idling, a mostly idle sender, a
      // mostly stalling receiver, then light idling on both sides. Filling
      // and draining stretches alternate every hundred requests.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin sender_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_request(((n / 100) % 2) == 0), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      // Keep watching afterwards so that a stray extra response is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/tscrt_pkg.sv
rtl/core/tscrt_cell.sv
rtl/core/time_sorted_call_record_table_top.sv
rtl/core/tscrt_checker.sv
dv/tb_top.sv
